// ===== design/temperature_fan_curve_controller_macros.svh =====
// Assertion macros for the fan curve controller.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef TEMPERATURE_FAN_CURVE_CONTROLLER_MACROS_SVH
`define TEMPERATURE_FAN_CURVE_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define TFC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fan curve controller: property violated");
`define TFC_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("fan curve controller: forbidden condition");
`else
`define TFC_ASSERT(lbl, prop)
`define TFC_NEVER(lbl, expr)
`endif
`endif

// ===== design/tfc_pkg.sv =====
// Shared widths, codes and payload types of the fan curve controller.
// No dependencies; used by the interfaces, the serial arithmetic unit and the top level.
package tfc_pkg;

    localparam int TEMP_W         = 7;
    localparam int RPM_W          = 14;
    localparam int TEMP_FRAC_BITS = 8;
    localparam int AVG_W          = TEMP_W + TEMP_FRAC_BITS;
    localparam int CMP_W          = AVG_W + 2;

    localparam int PRE_BAND_DEG = 10;
    localparam int RPM_QUANTUM  = 100;
    localparam int PRE_DEN      = PRE_BAND_DEG << TEMP_FRAC_BITS;

    // Serial unit: SER_W multiplier bits or quotient bits, one per cycle.
    localparam int SER_W  = (AVG_W > RPM_W + 1) ? AVG_W : RPM_W + 1;
    localparam int PROD_W = RPM_W + SER_W;
    localparam int DVD_W  = PROD_W + 1;
    localparam int DIV_W  = AVG_W + 1;
    localparam int OPB_W  = (DIV_W > RPM_W) ? DIV_W : RPM_W;
    localparam int ACC_W  = (RPM_W + 1 > DIV_W) ? RPM_W + 1 : DIV_W;
    localparam int CNT_W  = $clog2(SER_W);

    localparam int CFG_IDX_W = 3;

    localparam logic [TEMP_W-1:0] CPU_LOW_RST   = TEMP_W'(65);
    localparam logic [TEMP_W-1:0] CPU_HIGH_RST  = TEMP_W'(90);
    localparam logic [TEMP_W-1:0] GPU_LOW_RST   = TEMP_W'(70);
    localparam logic [TEMP_W-1:0] GPU_HIGH_RST  = TEMP_W'(82);
    localparam logic [RPM_W-1:0]  IDLE_RPM_RST  = RPM_W'(2200);
    localparam logic [RPM_W-1:0]  ENGAGE_RPM_RST = RPM_W'(2500);
    localparam logic [RPM_W-1:0]  MAX_RPM_RST   = RPM_W'(4800);
    localparam logic [RPM_W-1:0]  STEP_RST      = RPM_W'(150);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CPU_LOW_TEMP,
        CFG_CPU_HIGH_TEMP,
        CFG_GPU_LOW_TEMP,
        CFG_GPU_HIGH_TEMP,
        CFG_IDLE_RPM,
        CFG_ENGAGE_RPM,
        CFG_MAX_RPM,
        CFG_CHANGE_STEP
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CH_START,
        S_MUL,
        S_DIV,
        S_FLOOR,
        S_FLOOR_WAIT
    } state_t;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_cmd_t;

    typedef struct packed {
        logic              restart;
        logic [TEMP_W-1:0] cpu_temp;
        logic              cpu_valid;
        logic [TEMP_W-1:0] gpu_temp;
        logic              gpu_valid;
    } sample_t;

    typedef struct packed {
        logic [RPM_W-1:0] target_rpm;
        logic             over_temp;
        logic             issue_setting;
        logic             auto_setting;
    } result_t;

endpackage

// ===== design/tfc_if.sv =====
// Valid/ready channel interfaces for temperature samples and fan results.
// Depends on tfc_pkg for the payload types.
interface tfc_sample_if;
    logic             valid;
    logic             ready;
    tfc_pkg::sample_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tfc_result_if;
    logic             valid;
    logic             ready;
    tfc_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/temperature_fan_curve_controller.sv =====
// Fan curve controller top level: averaging, curve, alarm and setting decision.
// Uses tfc_pkg, tfc_if and tfc_arith. One item at a time: the serial multiply/divide unit
// runs two operations per ramped channel plus one divide by 100. The next item is taken the
// cycle after the result is loaded. Reset clears the average and applied-setting valid
// flags and loads the register defaults.
`include "temperature_fan_curve_controller_macros.svh"

module temperature_fan_curve_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    tfc_sample_if.sink                      sample,
    tfc_result_if.source                    result,
    input  logic                            cfg_we,
    input  logic [tfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tfc_pkg::RPM_W-1:0]       cfg_data
);

    // Configuration registers.
    logic [tfc_pkg::TEMP_W-1:0] cpu_low_reg, cpu_high_reg, gpu_low_reg, gpu_high_reg;
    logic [tfc_pkg::RPM_W-1:0]  idle_rpm_reg, engage_rpm_reg, max_rpm_reg, step_reg;

    // Block state and per-item working registers.
    tfc_pkg::state_t            state_reg, state_next;
    logic [tfc_pkg::AVG_W-1:0]  cpu_avg_reg, cpu_avg_next, gpu_avg_reg, gpu_avg_next;
    logic                       cpu_avg_valid_reg, cpu_avg_valid_next;
    logic                       gpu_avg_valid_reg, gpu_avg_valid_next;
    logic [tfc_pkg::RPM_W-1:0]  applied_rpm_reg, applied_rpm_next;
    logic                       applied_valid_reg, applied_valid_next;
    logic                       alarm_reg, alarm_next;
    logic                       ch_reg, ch_next;
    logic [tfc_pkg::RPM_W-1:0]  best_reg, best_next;
    logic                       n2_neg_reg, n2_neg_next;
    logic                       out_valid_reg, out_valid_next;
    tfc_pkg::result_t           out_data_reg, out_data_next;

    // Serial unit connection.
    tfc_pkg::arith_cmd_t        arith_cmd;
    logic [tfc_pkg::DVD_W-1:0]  arith_opa;
    logic [tfc_pkg::OPB_W-1:0]  arith_opb;
    logic                       arith_busy;
    logic [tfc_pkg::PROD_W-1:0] arith_prod;
    logic [tfc_pkg::SER_W-1:0]  arith_quo;
    logic [tfc_pkg::DIV_W-1:0]  arith_rem;

    // Input side.
    logic [tfc_pkg::AVG_W-1:0]  prev_cpu_avg, prev_gpu_avg;
    logic                       prev_cpu_valid, prev_gpu_valid;
    logic                       in_alarm;

    // Curve selection for the current channel.
    logic [tfc_pkg::AVG_W-1:0]      ch_avg;
    logic                           ch_valid;
    logic [tfc_pkg::TEMP_W-1:0]     ch_lo, ch_hi;
    logic [tfc_pkg::TEMP_W+1:0]     lo_m10;
    logic signed [tfc_pkg::CMP_W-1:0] a_s, base_s, lo_q, hi_q, x_full, den_full;
    logic                           in_zero, in_pre, in_max;
    logic [tfc_pkg::AVG_W-1:0]      ramp_x, ramp_den;
    logic [tfc_pkg::RPM_W-1:0]      ramp_start, ramp_end, rdiff_mag;
    logic [tfc_pkg::RPM_W:0]        rdiff;
    logic                           rdiff_neg;
    logic [tfc_pkg::PROD_W:0]       two_p, den_ext, n2_mag;
    logic                           n2_neg;
    logic signed [tfc_pkg::RPM_W+1:0] start_ext, q_ext, curve_val;
    logic [tfc_pkg::RPM_W-1:0]      curve_rpm;
    logic                           ch_finish;
    logic [tfc_pkg::RPM_W-1:0]      ch_value;

    // Output decision.
    logic [tfc_pkg::RPM_W-1:0]      target_val, rpm_gap;
    logic                           issue;

    function automatic logic [tfc_pkg::AVG_W-1:0] avg_update(
        input logic [tfc_pkg::AVG_W-1:0]  avg,
        input logic                       seeded,
        input logic [tfc_pkg::TEMP_W-1:0] temp
    );
        logic [tfc_pkg::AVG_W-1:0] s;
        logic [tfc_pkg::AVG_W-1:0] gap;
        logic [tfc_pkg::AVG_W:0]   gap3;
        s = {temp, {tfc_pkg::TEMP_FRAC_BITS{1'b0}}};
        if (!seeded)
        begin
            return s;
        end
        if (s > avg)
        begin
            gap = s - avg;
            return avg + (gap >> 1);
        end
        // Falling: floor(avg - gap/4) is avg minus the gap/4 rounded up.
        gap  = avg - s;
        gap3 = {1'b0, gap} + (tfc_pkg::AVG_W + 1)'(3);
        return avg - tfc_pkg::AVG_W'(gap3 >> 2);
    endfunction

    tfc_arith u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (arith_cmd),
        .opa       (arith_opa),
        .opb       (arith_opb),
        .busy      (arith_busy),
        .product   (arith_prod),
        .quotient  (arith_quo),
        .remainder (arith_rem)
    );

    assign sample.ready = (state_reg == tfc_pkg::S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // A restart clears the history before this sample is applied.
    always_comb
    begin
        prev_cpu_avg   = sample.data.restart ? '0 : cpu_avg_reg;
        prev_cpu_valid = !sample.data.restart && cpu_avg_valid_reg;
        prev_gpu_avg   = sample.data.restart ? '0 : gpu_avg_reg;
        prev_gpu_valid = !sample.data.restart && gpu_avg_valid_reg;
        in_alarm = (sample.data.cpu_valid && (sample.data.cpu_temp >= cpu_high_reg))
                || (sample.data.gpu_valid && (sample.data.gpu_temp >= gpu_high_reg));
    end

    always_comb
    begin
        ch_avg   = ch_reg ? gpu_avg_reg : cpu_avg_reg;
        ch_valid = ch_reg ? gpu_avg_valid_reg : cpu_avg_valid_reg;
        ch_lo    = ch_reg ? gpu_low_reg : cpu_low_reg;
        ch_hi    = ch_reg ? gpu_high_reg : cpu_high_reg;

        // The zero region starts at lo - 10, which goes negative for small lo.
        lo_m10 = {2'b00, ch_lo} - (tfc_pkg::TEMP_W + 2)'(tfc_pkg::PRE_BAND_DEG);
        a_s    = $signed({2'b00, ch_avg});
        base_s = $signed({lo_m10, {tfc_pkg::TEMP_FRAC_BITS{1'b0}}});
        lo_q   = $signed({2'b00, ch_lo, {tfc_pkg::TEMP_FRAC_BITS{1'b0}}});
        hi_q   = $signed({2'b00, ch_hi, {tfc_pkg::TEMP_FRAC_BITS{1'b0}}});

        in_zero = (a_s <= base_s);
        in_pre  = (a_s < lo_q);
        in_max  = (a_s >= hi_q);

        x_full   = in_pre ? (a_s - base_s) : (a_s - lo_q);
        den_full = hi_q - lo_q;
        ramp_x   = x_full[tfc_pkg::AVG_W-1:0];
        ramp_den = in_pre ? tfc_pkg::AVG_W'(tfc_pkg::PRE_DEN) : den_full[tfc_pkg::AVG_W-1:0];

        ramp_start = in_pre ? idle_rpm_reg : engage_rpm_reg;
        ramp_end   = in_pre ? engage_rpm_reg : max_rpm_reg;
        rdiff      = {1'b0, ramp_end} - {1'b0, ramp_start};
        rdiff_neg  = rdiff[tfc_pkg::RPM_W];
        rdiff_mag  = rdiff_neg ? tfc_pkg::RPM_W'(~rdiff + 1'b1) : rdiff[tfc_pkg::RPM_W-1:0];

        // Rounded quotient: trunc((2n + d) / 2d), done on the magnitude with the sign
        // carried aside.
        two_p   = {arith_prod, 1'b0};
        den_ext = (tfc_pkg::PROD_W + 1)'(ramp_den);
        if (!rdiff_neg)
        begin
            n2_mag = two_p + den_ext;
            n2_neg = 1'b0;
        end
        else if (two_p > den_ext)
        begin
            n2_mag = two_p - den_ext;
            n2_neg = 1'b1;
        end
        else
        begin
            n2_mag = den_ext - two_p;
            n2_neg = 1'b0;
        end

        start_ext = $signed({2'b00, ramp_start});
        q_ext     = $signed({1'b0, arith_quo[tfc_pkg::RPM_W:0]});
        curve_val = n2_neg_reg ? (start_ext - q_ext) : (start_ext + q_ext);
        curve_rpm = curve_val[tfc_pkg::RPM_W+1] ? '0 : curve_val[tfc_pkg::RPM_W-1:0];
    end

    always_comb
    begin
        target_val = best_reg - tfc_pkg::RPM_W'(arith_rem);
        rpm_gap    = (target_val >= applied_rpm_reg) ? (target_val - applied_rpm_reg)
                                                     : (applied_rpm_reg - target_val);
        issue      = !applied_valid_reg || alarm_reg || (rpm_gap >= step_reg);
    end

    always_comb
    begin
        state_next         = state_reg;
        cpu_avg_next       = cpu_avg_reg;
        cpu_avg_valid_next = cpu_avg_valid_reg;
        gpu_avg_next       = gpu_avg_reg;
        gpu_avg_valid_next = gpu_avg_valid_reg;
        applied_rpm_next   = applied_rpm_reg;
        applied_valid_next = applied_valid_reg;
        alarm_next         = alarm_reg;
        ch_next            = ch_reg;
        best_next          = best_reg;
        n2_neg_next        = n2_neg_reg;
        out_valid_next     = out_valid_reg && !result.ready;
        out_data_next      = out_data_reg;
        arith_cmd.start    = 1'b0;
        arith_cmd.op       = tfc_pkg::OP_MUL;
        arith_opa          = '0;
        arith_opb          = '0;
        ch_finish          = 1'b0;
        ch_value           = '0;

        unique case (state_reg)
            tfc_pkg::S_IDLE:
            begin
                if (sample.valid)
                begin
                    if (sample.data.cpu_valid)
                    begin
                        cpu_avg_next = avg_update(prev_cpu_avg, prev_cpu_valid,
                                                  sample.data.cpu_temp);
                    end
                    else
                    begin
                        cpu_avg_next = prev_cpu_avg;
                    end
                    cpu_avg_valid_next = sample.data.cpu_valid || prev_cpu_valid;
                    // An invalid GPU reading drops the GPU average entirely.
                    gpu_avg_next = sample.data.gpu_valid ?
                                   avg_update(prev_gpu_avg, prev_gpu_valid,
                                              sample.data.gpu_temp) : '0;
                    gpu_avg_valid_next = sample.data.gpu_valid;
                    if (sample.data.restart)
                    begin
                        applied_rpm_next   = '0;
                        applied_valid_next = 1'b0;
                    end
                    alarm_next = in_alarm;
                    ch_next    = 1'b0;
                    best_next  = '0;
                    state_next = tfc_pkg::S_CH_START;
                end
            end
            tfc_pkg::S_CH_START:
            begin
                if (!ch_valid || in_zero)
                begin
                    ch_finish = 1'b1;
                    ch_value  = '0;
                end
                else if (!in_pre && in_max)
                begin
                    ch_finish = 1'b1;
                    ch_value  = max_rpm_reg;
                end
                else
                begin
                    arith_cmd.start = 1'b1;
                    arith_cmd.op    = tfc_pkg::OP_MUL;
                    arith_opa       = tfc_pkg::DVD_W'(ramp_x);
                    arith_opb       = tfc_pkg::OPB_W'(rdiff_mag);
                    state_next      = tfc_pkg::S_MUL;
                end
            end
            tfc_pkg::S_MUL:
            begin
                if (!arith_busy)
                begin
                    arith_cmd.start = 1'b1;
                    arith_cmd.op    = tfc_pkg::OP_DIV;
                    arith_opa       = tfc_pkg::DVD_W'(n2_mag);
                    arith_opb       = tfc_pkg::OPB_W'({ramp_den, 1'b0});
                    n2_neg_next     = n2_neg;
                    state_next      = tfc_pkg::S_DIV;
                end
            end
            tfc_pkg::S_DIV:
            begin
                if (!arith_busy)
                begin
                    ch_finish = 1'b1;
                    ch_value  = curve_rpm;
                end
            end
            tfc_pkg::S_FLOOR:
            begin
                best_next       = alarm_reg ? max_rpm_reg : best_reg;
                arith_cmd.start = 1'b1;
                arith_cmd.op    = tfc_pkg::OP_DIV;
                arith_opa       = tfc_pkg::DVD_W'(alarm_reg ? max_rpm_reg : best_reg);
                arith_opb       = tfc_pkg::OPB_W'(tfc_pkg::RPM_QUANTUM);
                state_next      = tfc_pkg::S_FLOOR_WAIT;
            end
            tfc_pkg::S_FLOOR_WAIT:
            begin
                // The divider holds its remainder, so waiting on a full output is safe.
                if (!arith_busy && (!out_valid_reg || result.ready))
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.target_rpm    = target_val;
                    out_data_next.over_temp     = alarm_reg;
                    out_data_next.issue_setting = issue;
                    out_data_next.auto_setting  = issue && (target_val == '0);
                    if (issue)
                    begin
                        applied_rpm_next   = target_val;
                        applied_valid_next = 1'b1;
                    end
                    state_next = tfc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tfc_pkg::S_IDLE;
            end
        endcase

        if (ch_finish)
        begin
            if (ch_value > best_reg)
            begin
                best_next = ch_value;
            end
            if (!ch_reg)
            begin
                ch_next    = 1'b1;
                state_next = tfc_pkg::S_CH_START;
            end
            else
            begin
                state_next = tfc_pkg::S_FLOOR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= tfc_pkg::S_IDLE;
            cpu_avg_valid_reg <= 1'b0;
            gpu_avg_valid_reg <= 1'b0;
            applied_valid_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            cpu_low_reg       <= tfc_pkg::CPU_LOW_RST;
            cpu_high_reg      <= tfc_pkg::CPU_HIGH_RST;
            gpu_low_reg       <= tfc_pkg::GPU_LOW_RST;
            gpu_high_reg      <= tfc_pkg::GPU_HIGH_RST;
            idle_rpm_reg      <= tfc_pkg::IDLE_RPM_RST;
            engage_rpm_reg    <= tfc_pkg::ENGAGE_RPM_RST;
            max_rpm_reg       <= tfc_pkg::MAX_RPM_RST;
            step_reg          <= tfc_pkg::STEP_RST;
        end
        else
        begin
            state_reg         <= state_next;
            cpu_avg_valid_reg <= cpu_avg_valid_next;
            gpu_avg_valid_reg <= gpu_avg_valid_next;
            applied_valid_reg <= applied_valid_next;
            out_valid_reg     <= out_valid_next;
            if (cfg_we)
            begin
                unique case (tfc_pkg::cfg_reg_t'(cfg_index))
                    tfc_pkg::CFG_CPU_LOW_TEMP:  cpu_low_reg    <= cfg_data[tfc_pkg::TEMP_W-1:0];
                    tfc_pkg::CFG_CPU_HIGH_TEMP: cpu_high_reg   <= cfg_data[tfc_pkg::TEMP_W-1:0];
                    tfc_pkg::CFG_GPU_LOW_TEMP:  gpu_low_reg    <= cfg_data[tfc_pkg::TEMP_W-1:0];
                    tfc_pkg::CFG_GPU_HIGH_TEMP: gpu_high_reg   <= cfg_data[tfc_pkg::TEMP_W-1:0];
                    tfc_pkg::CFG_IDLE_RPM:      idle_rpm_reg   <= cfg_data;
                    tfc_pkg::CFG_ENGAGE_RPM:    engage_rpm_reg <= cfg_data;
                    tfc_pkg::CFG_MAX_RPM:       max_rpm_reg    <= cfg_data;
                    tfc_pkg::CFG_CHANGE_STEP:   step_reg       <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cpu_avg_reg     <= cpu_avg_next;
        gpu_avg_reg     <= gpu_avg_next;
        applied_rpm_reg <= applied_rpm_next;
        alarm_reg       <= alarm_next;
        ch_reg          <= ch_next;
        best_reg        <= best_next;
        n2_neg_reg      <= n2_neg_next;
        out_data_reg    <= out_data_next;
    end

    `TFC_ASSERT(a_unit_busy_in_wait_state, arith_busy |-> (state_reg == tfc_pkg::S_MUL || state_reg == tfc_pkg::S_DIV || state_reg == tfc_pkg::S_FLOOR_WAIT))
    `TFC_NEVER(a_no_start_while_busy, arith_cmd.start && arith_busy)
    `TFC_ASSERT(a_alarm_issues_setting, (result.valid && result.data.over_temp) |-> result.data.issue_setting)
    `TFC_ASSERT(a_applied_after_result, $rose(out_valid_reg) |-> applied_valid_reg)

endmodule

// ===== design/tfc_arith.sv =====
// Bit-serial shift-add multiplier and restoring divider sharing one datapath.
// Depends on tfc_pkg; one multiplier bit or one quotient bit per clock.
module tfc_arith (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tfc_pkg::arith_cmd_t          cmd,
    input  logic [tfc_pkg::DVD_W-1:0]    opa,
    input  logic [tfc_pkg::OPB_W-1:0]    opb,
    output logic                         busy,
    output logic [tfc_pkg::PROD_W-1:0]   product,
    output logic [tfc_pkg::SER_W-1:0]    quotient,
    output logic [tfc_pkg::DIV_W-1:0]    remainder
);

    logic                          busy_reg, busy_next;
    tfc_pkg::arith_op_t            op_reg, op_next;
    logic [tfc_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [tfc_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [tfc_pkg::SER_W-1:0]     work_reg, work_next;
    logic [tfc_pkg::OPB_W-1:0]     opb_reg, opb_next;
    logic [tfc_pkg::RPM_W:0]       mul_sum;
    logic [tfc_pkg::DIV_W:0]       trial;
    logic [tfc_pkg::DIV_W:0]       trial_diff;
    logic                          trial_ge;

    // Multiply: the multiplier sits in work_reg and shifts out at the bottom while
    // the partial sum shifts in at the top. Divide: the dividend low bits shift out
    // of work_reg into the remainder while quotient bits shift in.
    assign mul_sum = {1'b0, acc_reg[tfc_pkg::RPM_W-1:0]}
                   + (work_reg[0] ? {1'b0, opb_reg[tfc_pkg::RPM_W-1:0]}
                                  : {(tfc_pkg::RPM_W + 1){1'b0}});
    assign trial      = {acc_reg[tfc_pkg::DIV_W-1:0], work_reg[tfc_pkg::SER_W-1]};
    assign trial_diff = trial - {1'b0, opb_reg[tfc_pkg::DIV_W-1:0]};
    assign trial_ge   = (trial >= {1'b0, opb_reg[tfc_pkg::DIV_W-1:0]});

    always_comb
    begin
        busy_next  = busy_reg;
        op_next    = op_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        work_next  = work_reg;
        opb_next   = opb_reg;
        if (cmd.start)
        begin
            busy_next  = 1'b1;
            op_next    = cmd.op;
            count_next = tfc_pkg::CNT_W'(tfc_pkg::SER_W - 1);
            opb_next   = opb;
            work_next  = opa[tfc_pkg::SER_W-1:0];
            // The caller guarantees the quotient fits SER_W bits, so the upper
            // dividend bits are already below the divisor.
            acc_next   = (cmd.op == tfc_pkg::OP_DIV) ?
                         tfc_pkg::ACC_W'(opa >> tfc_pkg::SER_W) : '0;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                tfc_pkg::OP_MUL:
                begin
                    acc_next  = tfc_pkg::ACC_W'(mul_sum >> 1);
                    work_next = {mul_sum[0], work_reg[tfc_pkg::SER_W-1:1]};
                end
                tfc_pkg::OP_DIV:
                begin
                    acc_next  = trial_ge ? tfc_pkg::ACC_W'(trial_diff[tfc_pkg::DIV_W-1:0])
                                         : tfc_pkg::ACC_W'(trial[tfc_pkg::DIV_W-1:0]);
                    work_next = {work_reg[tfc_pkg::SER_W-2:0], trial_ge};
                end
            endcase
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            op_reg    <= tfc_pkg::OP_MUL;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            op_reg    <= op_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        work_reg <= work_next;
        opb_reg  <= opb_next;
    end

    assign busy      = busy_reg;
    assign product   = {acc_reg[tfc_pkg::RPM_W-1:0], work_reg};
    assign quotient  = work_reg;
    assign remainder = acc_reg[tfc_pkg::DIV_W-1:0];

endmodule

// ===== sim/fan_target_checker.sv =====
// Scoreboard for the fan curve controller: predicts each fan result from the accepted
// samples and register writes, and compares it with what the result channel delivers.
// Depends on tfc_pkg and the channel interfaces of tfc_if.
module fan_target_checker
    import tfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    tfc_sample_if                sample,
    tfc_result_if                result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RPM_W-1:0]     cfg_data,
    output int                   mismatches,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    int unsigned cpu_low, cpu_high, gpu_low, gpu_high;
    int unsigned idle_speed, engage_speed, max_speed, min_change;
    int unsigned cpu_avg, gpu_avg, applied_speed;
    bit          cpu_seeded, gpu_seeded, applied_known;
    result_t     expected_results[$];
    result_t     oldest;

    function automatic int unsigned smooth_step(int unsigned avg, bit seeded,
                                                int unsigned temp);
        int unsigned level;
        level = temp << TEMP_FRAC_BITS;
        if (!seeded)
            return level;
        if (level > avg)
            return avg + ((level - avg) >> 1);
        // Falling or level: flooring the new average rounds the quarter gap up.
        return avg - (((avg - level) + 3) >> 2);
    endfunction

    // Truncates num/den + 1/2 toward zero; den is always positive.
    function automatic longint rounded_quotient(longint num, longint den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic longint curve_speed(int unsigned avg, int unsigned lo,
                                           int unsigned hi);
        longint one, a, base, lo_q, hi_q;
        one  = longint'(1) << TEMP_FRAC_BITS;
        a    = longint'(avg);
        base = (longint'(lo) - PRE_BAND_DEG) * one;
        lo_q = longint'(lo) * one;
        hi_q = longint'(hi) * one;
        if (a <= base)
            return 0;
        if (a < lo_q)
            return longint'(idle_speed) +
                   rounded_quotient((longint'(engage_speed) - longint'(idle_speed)) *
                                    (a - base), PRE_BAND_DEG * one);
        if (a >= hi_q)
            return longint'(max_speed);
        return longint'(engage_speed) +
               rounded_quotient((longint'(max_speed) - longint'(engage_speed)) *
                                (a - lo_q), hi_q - lo_q);
    endfunction

    function automatic result_t predict_fan_result(sample_t s);
        result_t     r;
        longint      cpu_speed, gpu_speed, speed;
        int unsigned target, gap;
        bit          alarm, issue;
        cpu_speed = 0;
        gpu_speed = 0;
        if (s.restart)
        begin
            cpu_avg       = 0;
            cpu_seeded    = 1'b0;
            gpu_avg       = 0;
            gpu_seeded    = 1'b0;
            applied_speed = 0;
            applied_known = 1'b0;
        end
        if (s.cpu_valid)
        begin
            cpu_avg    = smooth_step(cpu_avg, cpu_seeded, s.cpu_temp);
            cpu_seeded = 1'b1;
        end
        // The GPU average does not survive an invalid reading.
        if (s.gpu_valid)
        begin
            gpu_avg    = smooth_step(gpu_avg, gpu_seeded, s.gpu_temp);
            gpu_seeded = 1'b1;
        end
        else
        begin
            gpu_avg    = 0;
            gpu_seeded = 1'b0;
        end
        alarm = (s.cpu_valid && s.cpu_temp >= cpu_high) ||
                (s.gpu_valid && s.gpu_temp >= gpu_high);
        if (cpu_seeded)
            cpu_speed = curve_speed(cpu_avg, cpu_low, cpu_high);
        if (gpu_seeded)
            gpu_speed = curve_speed(gpu_avg, gpu_low, gpu_high);
        speed = (cpu_speed > gpu_speed) ? cpu_speed : gpu_speed;
        if (alarm)
            speed = max_speed;
        if (speed < 0)
            speed = 0;
        target = (speed / RPM_QUANTUM) * RPM_QUANTUM % (longint'(1) << RPM_W);
        if (target >= applied_speed)
            gap = target - applied_speed;
        else
            gap = applied_speed - target;
        issue = !applied_known || alarm || gap >= min_change;
        if (issue)
        begin
            applied_speed = target;
            applied_known = 1'b1;
        end
        r.target_rpm    = RPM_W'(target);
        r.over_temp     = alarm;
        r.issue_setting = issue;
        r.auto_setting  = issue && target == 0;
        return r;
    endfunction

    task automatic compare_field(string field, logic [RPM_W-1:0] want,
                                 logic [RPM_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_low       = CPU_LOW_RST;
            cpu_high      = CPU_HIGH_RST;
            gpu_low       = GPU_LOW_RST;
            gpu_high      = GPU_HIGH_RST;
            idle_speed    = IDLE_RPM_RST;
            engage_speed  = ENGAGE_RPM_RST;
            max_speed     = MAX_RPM_RST;
            min_change    = STEP_RST;
            cpu_avg       = 0;
            cpu_seeded    = 1'b0;
            gpu_avg       = 0;
            gpu_seeded    = 1'b0;
            applied_speed = 0;
            applied_known = 1'b0;
            mismatches    = 0;
            expected_results.delete();
            outstanding   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_CPU_LOW_TEMP:  cpu_low      = cfg_data[TEMP_W-1:0];
                    CFG_CPU_HIGH_TEMP: cpu_high     = cfg_data[TEMP_W-1:0];
                    CFG_GPU_LOW_TEMP:  gpu_low      = cfg_data[TEMP_W-1:0];
                    CFG_GPU_HIGH_TEMP: gpu_high     = cfg_data[TEMP_W-1:0];
                    CFG_IDLE_RPM:      idle_speed   = cfg_data;
                    CFG_ENGAGE_RPM:    engage_speed = cfg_data;
                    CFG_MAX_RPM:       max_speed    = cfg_data;
                    CFG_CHANGE_STEP:   min_change   = cfg_data;
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: result transfer with nothing expected, actual %p",
                             $time, result.data);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    compare_field("target_rpm", oldest.target_rpm, result.data.target_rpm);
                    compare_field("over_temp", oldest.over_temp, result.data.over_temp);
                    compare_field("issue_setting", oldest.issue_setting,
                                  result.data.issue_setting);
                    compare_field("auto_setting", oldest.auto_setting,
                                  result.data.auto_setting);
                end
            end
            if (sample.valid && sample.ready)
                expected_results.push_back(predict_fan_result(sample.data));
            outstanding = expected_results.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Top of the fan curve controller testbench: clock, reset, samples, register writes
// and result back-pressure. Depends on tfc_pkg, tfc_if, the controller and fan_target_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tfc_pkg::*;

    typedef enum {
        SET_TYPICAL,
        SET_WILD,
        SET_SPREAD,
        SET_NARROW,
        SET_PRE_BAND
    } setting_kind_t;

    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 108;

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we;
    cfg_reg_t         cfg_index;
    logic [RPM_W-1:0] cfg_data;
    int               mismatches;
    int               outstanding;
    bit               idling    = 1'b1;
    bit               long_hold = 1'b0;
    int               cpu_walk  = 60;
    int               gpu_walk  = 60;

    tfc_sample_if sample_ch ();
    tfc_result_if result_ch ();

    temperature_fan_curve_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fan_target_checker target_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample_ch),
        .result      (result_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    function automatic sample_t make_sample(bit restart, int cpu_t, bit cpu_v,
                                            int gpu_t, bit gpu_v);
        sample_t s;
        s.restart   = restart;
        s.cpu_temp  = TEMP_W'(cpu_t);
        s.cpu_valid = cpu_v;
        s.gpu_temp  = TEMP_W'(gpu_t);
        s.gpu_valid = gpu_v;
        return s;
    endfunction

    // Mostly slow temperature drifts so the averages settle into every curve region;
    // one item in ten is unrelated noise.
    function automatic sample_t random_sample();
        int drift;
        if ($urandom_range(0, 9) == 0)
            return make_sample($urandom_range(0, 3) == 0, $urandom_range(0, 127),
                               $urandom_range(0, 1), $urandom_range(0, 127),
                               $urandom_range(0, 1));
        drift    = $urandom_range(0, 12);
        cpu_walk = cpu_walk + drift - 6;
        drift    = $urandom_range(0, 12);
        gpu_walk = gpu_walk + drift - 6;
        if ($urandom_range(0, 19) == 0)
            cpu_walk = $urandom_range(0, 127);
        if ($urandom_range(0, 19) == 0)
            gpu_walk = $urandom_range(0, 127);
        if (cpu_walk < 0)
            cpu_walk = 0;
        if (cpu_walk > 127)
            cpu_walk = 127;
        if (gpu_walk < 0)
            gpu_walk = 0;
        if (gpu_walk > 127)
            gpu_walk = 127;
        return make_sample($urandom_range(0, 49) == 0, cpu_walk, $urandom_range(0, 9) != 0,
                           gpu_walk, $urandom_range(0, 7) != 0);
    endfunction

    // Temperature registers are seven bits wide; the upper data bits carry noise.
    function automatic logic [RPM_W-1:0] temp_word(int degrees);
        logic [RPM_W-TEMP_W-1:0] noise;
        noise = $urandom;
        return {noise, TEMP_W'(degrees)};
    endfunction

    task automatic send_sample(sample_t s);
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= s;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Stop offering samples and wait until every expected result has been taken.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t index, logic [RPM_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic program_registers(setting_kind_t kind);
        int cl, ch, gl, gh, idle, eng, mx, step;
        case (kind)
            SET_TYPICAL:
            begin
                cl   = $urandom_range(30, 100);
                ch   = $urandom_range(cl + 1, 127);
                gl   = $urandom_range(30, 100);
                gh   = $urandom_range(gl + 1, 127);
                idle = $urandom_range(0, 3000);
                eng  = $urandom_range(idle, 6000);
                mx   = $urandom_range(eng, 9900);
                step = $urandom_range(0, 600);
            end
            SET_WILD:
            begin
                cl   = $urandom_range(0, 127);
                ch   = $urandom_range(0, 127);
                gl   = $urandom_range(0, 127);
                gh   = $urandom_range(0, 127);
                idle = $urandom_range(0, 16383);
                eng  = $urandom_range(0, 16383);
                mx   = $urandom_range(0, 16383);
                step = $urandom_range(0, 2000);
            end
            SET_SPREAD:
            begin
                cl   = 10;
                ch   = 127;
                gl   = 127;
                gh   = 10;
                idle = 9900;
                eng  = 0;
                mx   = 16383;
                step = 0;
            end
            SET_NARROW:
            begin
                cl   = 0;
                ch   = 0;
                gl   = 9;
                gh   = 127;
                idle = 0;
                eng  = 9900;
                mx   = 0;
                step = 16383;
            end
            default:
            begin
                // Low below ten on the CPU, high below low on the GPU, falling pre-band ramp.
                cl   = 0;
                ch   = 5;
                gl   = 50;
                gh   = 40;
                idle = 9900;
                eng  = 100;
                mx   = 16383;
                step = 0;
            end
        endcase
        write_reg(CFG_CPU_LOW_TEMP, temp_word(cl));
        write_reg(CFG_CPU_HIGH_TEMP, temp_word(ch));
        write_reg(CFG_GPU_LOW_TEMP, temp_word(gl));
        write_reg(CFG_GPU_HIGH_TEMP, temp_word(gh));
        write_reg(CFG_IDLE_RPM, RPM_W'(idle));
        write_reg(CFG_ENGAGE_RPM, RPM_W'(eng));
        write_reg(CFG_MAX_RPM, RPM_W'(mx));
        write_reg(CFG_CHANGE_STEP, RPM_W'(step));
        cfg_we <= 1'b0;
    endtask

    // Result side: random stalls, plain stretches of readiness, and one long hold-off.
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (idling && $urandom_range(0, 3) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    initial
    begin
        sample_ch.valid = 1'b0;
        sample_ch.data  = '0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_CPU_LOW_TEMP;
        cfg_data        = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: seeding, both smoothing directions, alarms, invalid readings.
        send_sample(make_sample(1, 0, 0, 0, 0));
        send_sample(make_sample(0, 60, 1, 65, 1));
        send_sample(make_sample(0, 75, 1, 76, 1));
        send_sample(make_sample(0, 20, 1, 76, 0));
        send_sample(make_sample(0, 127, 1, 0, 0));
        send_sample(make_sample(0, 127, 0, 127, 0));
        send_sample(make_sample(0, 0, 1, 82, 1));
        send_sample(make_sample(0, 89, 1, 81, 1));
        send_sample(make_sample(0, 90, 1, 1, 1));
        send_sample(make_sample(0, 85, 1, 42, 1));
        send_sample(make_sample(0, 42, 1, 85, 1));
        send_sample(make_sample(1, 127, 1, 127, 1));
        send_sample(make_sample(0, 0, 1, 0, 1));
        send_sample(make_sample(1, 64, 1, 69, 1));

        settle();
        program_registers(SET_PRE_BAND);
        send_sample(make_sample(1, 0, 1, 45, 1));
        send_sample(make_sample(0, 3, 1, 60, 1));
        send_sample(make_sample(0, 4, 1, 40, 1));
        send_sample(make_sample(0, 127, 0, 30, 1));
        send_sample(make_sample(0, 5, 1, 127, 0));
        send_sample(make_sample(0, 0, 1, 0, 1));
        send_sample(make_sample(0, 2, 1, 49, 1));
        send_sample(make_sample(1, 0, 0, 55, 1));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case (phase)
                1:       program_registers(SET_WILD);
                2:       program_registers(SET_SPREAD);
                4:       program_registers(SET_NARROW);
                default: program_registers(SET_TYPICAL);
            endcase
            idling = (phase != 1) && (phase != PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 0 && n == 40)
                    long_hold = 1'b1;
                send_sample(random_sample());
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== temperature_fan_curve_controller.f =====
+incdir+design
design/tfc_pkg.sv
design/tfc_if.sv
design/tfc_arith.sv
design/temperature_fan_curve_controller.sv
sim/fan_target_checker.sv
sim/tb_top.sv
